[sv/steim1_block_decompressor_assert.svh]
// Assertion macros for the Steim-1 decompressor checker.
`ifndef STEIM1_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define STEIM1_BLOCK_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STEIM1_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steim1 assertion failed");

// Next-cycle implication, disabled while reset is held.
`define STEIM1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steim1 assertion failed");

// Next-cycle implication that is also checked across reset.
`define STEIM1_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("steim1 assertion failed");

`endif

[sv/steim1_pkg.sv]
// Types and constants shared by the Steim-1 block decompressor modules.
package steim1_pkg;

  localparam int WordW   = 32;
  localparam int IndexW  = 12;
  localparam int MaxDiff = 4;

  // Block word positions with a special meaning.
  localparam int HeaderWords = 16;
  localparam int X0Pos       = 17;
  localparam int XnPos       = 18;

  // Two-bit difference codes from the frame control word.
  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] CODE_BYTES  = 2'd1;
  localparam logic [1:0] CODE_HALVES = 2'd2;
  localparam logic [1:0] CODE_WORD   = 2'd3;

  // Everything one decoded word hands to the output buffer.
  typedef struct packed {
    logic [2:0]                      num;
    logic [IndexW-1:0]               idx_base;
    logic [MaxDiff-1:0][WordW-1:0]   samples;
  } word_res_t;

endpackage

[sv/steim1_decode.sv]
// Word decoder: block state, control word capture and sample reconstruction.
module steim1_decode
  import steim1_pkg::*;
#(
  parameter int MAX_BLOCK_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             accept,
  input  logic [WordW-1:0] data_word,
  input  logic             last_word,
  input  logic             forget_previous,
  output word_res_t        res
);

  localparam int PosW = $clog2(MAX_BLOCK_WORDS + 1);

  logic              byte_swap_r;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [WordW-1:0]  ctrl_r, ctrl_nxt;
  logic [WordW-1:0]  run_r, run_nxt;
  logic              prev_r, prev_nxt;
  logic              skip_r, skip_nxt;
  logic [WordW-1:0]  xn_r, xn_nxt;
  logic [IndexW-1:0] cnt_r, cnt_nxt;
  logic              seen_r, seen_nxt;

  logic [WordW-1:0]  w;
  logic              at_start, prev_eff, skip_eff, in_range, is_ctrl, decode_word;
  logic              load_x0;
  logic [1:0]        code;
  logic [2:0]        num;
  logic [WordW-1:0]  base;
  logic [MaxDiff-1:0][WordW-1:0] diff;
  logic [MaxDiff-1:0][WordW-1:0] samples;
  logic [WordW-1:0]  run_dec, xn_dec;
  logic              prev_dec, skip_dec, seen_dec;

  always_comb begin
    w = byte_swap_r ? {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]}
                    : data_word;

    // Forget only counts on the first word of a block.
    at_start = (pos_r == '0);
    prev_eff = at_start ? (prev_r & ~forget_previous) : prev_r;
    skip_eff = at_start ? ~prev_eff : skip_r;

    in_range    = (pos_r >= PosW'(HeaderWords)) && (pos_r < PosW'(MAX_BLOCK_WORDS));
    is_ctrl     = (pos_r[3:0] == 4'd0);
    decode_word = in_range & ~is_ctrl;

    // Code pairs run most significant first; frame offset k uses pair 15-k.
    code = ctrl_r[{~pos_r[3:0], 1'b0} +: 2];
  end

  always_comb begin
    logic [WordW-1:0] acc;
    acc  = '0;
    diff = '0;
    case (code)
      CODE_BYTES: begin
        num = 3'd4;
        for (int k = 0; k < MaxDiff; k++) begin
          diff[k] = {{(WordW-8){w[31-8*k]}}, w[31-8*k -: 8]};
        end
      end
      CODE_HALVES: begin
        num     = 3'd2;
        diff[0] = {{(WordW-16){w[31]}}, w[31:16]};
        diff[1] = {{(WordW-16){w[15]}}, w[15:0]};
      end
      CODE_WORD: begin
        num     = 3'd1;
        diff[0] = w;
      end
      default: begin
        num = 3'd0;
      end
    endcase
    if (!decode_word) begin
      num = 3'd0;
    end

    // The block's first sample is X0 itself, so its difference is dropped.
    if (skip_eff) begin
      diff[0] = '0;
    end

    load_x0 = decode_word && (pos_r == PosW'(X0Pos)) && skip_eff;
    base    = load_x0 ? w : run_r;

    for (int k = 0; k < MaxDiff; k++) begin
      acc        = acc + diff[k];
      samples[k] = base + acc;
    end

    run_dec  = (num == 3'd0) ? base : samples[2'(num - 3'd1)];
    prev_dec = prev_eff | load_x0;
    skip_dec = skip_eff & (num == 3'd0);
    xn_dec   = (decode_word && (pos_r == PosW'(XnPos))) ? w : xn_r;
    seen_dec = seen_r | (num != 3'd0);
  end

  always_comb begin
    pos_nxt  = pos_r;
    ctrl_nxt = ctrl_r;
    run_nxt  = run_r;
    prev_nxt = prev_r;
    skip_nxt = skip_r;
    xn_nxt   = xn_r;
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    if (accept) begin
      ctrl_nxt = (in_range && is_ctrl) ? w : ctrl_r;
      xn_nxt   = xn_dec;
      if (last_word) begin
        if (seen_dec) begin
          run_nxt  = (pos_r >= PosW'(XnPos)) ? xn_dec : run_dec;
          prev_nxt = 1'b1;
        end else begin
          run_nxt  = run_dec;
          prev_nxt = prev_dec;
        end
        pos_nxt  = '0;
        cnt_nxt  = '0;
        skip_nxt = 1'b0;
        seen_nxt = 1'b0;
      end else begin
        run_nxt  = run_dec;
        prev_nxt = prev_dec;
        skip_nxt = skip_dec;
        seen_nxt = seen_dec;
        cnt_nxt  = cnt_r + IndexW'(num);
        if (pos_r < PosW'(MAX_BLOCK_WORDS)) begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_swap_r <= 1'b0;
      pos_r       <= '0;
      ctrl_r      <= '0;
      run_r       <= '0;
      prev_r      <= 1'b0;
      skip_r      <= 1'b0;
      xn_r        <= '0;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        byte_swap_r <= cfg_wdata;
      end
      pos_r  <= pos_nxt;
      ctrl_r <= ctrl_nxt;
      run_r  <= run_nxt;
      prev_r <= prev_nxt;
      skip_r <= skip_nxt;
      xn_r   <= xn_nxt;
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_comb begin
    res.num      = num;
    res.idx_base = cnt_r;
    res.samples  = samples;
  end

endmodule

[sv/steim1_outbuf.sv]
// Result buffer: one word's samples, handed out one per cycle unless stalled.
module steim1_outbuf
  import steim1_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  word_res_t         res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [WordW-1:0]  sample,
  output logic [IndexW-1:0] sample_index,
  output logic              last_of_word,
  output logic              can_take
);

  logic [2:0]                    rem_r, rem_nxt;
  logic [1:0]                    rd_r, rd_nxt;
  logic [MaxDiff-1:0][WordW-1:0] samp_r;
  logic [IndexW-1:0]             base_r;
  logic                          take;

  assign out_tvalid   = (rem_r != 3'd0);
  assign take         = out_tvalid & out_tready;
  assign last_of_word = (rem_r == 3'd1);
  // A new word may land as the last buffered sample leaves.
  assign can_take     = (rem_r == 3'd0) || (last_of_word && out_tready);
  assign sample       = samp_r[rd_r];
  assign sample_index = base_r + IndexW'(rd_r);

  always_comb begin
    rem_nxt = rem_r;
    rd_nxt  = rd_r;
    if (load) begin
      rem_nxt = res.num;
      rd_nxt  = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 3'd1;
      rd_nxt  = rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      rd_r  <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      samp_r <= res.samples;
      base_r <= res.idx_base;
    end
  end

endmodule

[sv/steim1_block_decompressor.sv]
// Top level of the Steim-1 block decompressor.
//
//   Channel   Direction  Transfer when          Payload
//   in_*      input      in_tvalid & in_tready  tdata data_word, tlast last_word,
//                                               tuser forget_previous
//   out_*     output     out_tvalid&out_tready  tdata sample, sample_index;
//                                               tlast last_of_word
//   cfg_*     input      cfg_we                 cfg_wdata byte_swap
//
// A word is decoded in the cycle of its input transfer, and its zero to four samples
// are registered in the result buffer: four for a byte-difference word, none for
// header, control and zero-code words. Samples leave one per cycle while out_tready
// is high, and the result buffer's drain rate sets how fast words are taken.
// Reset (rst_n low at a clock edge) clears the block position, the held sample and
// the buffer. A stalled output holds its sample; input is taken again as the last
// buffered sample of the word transfers.
module steim1_block_decompressor
  import steim1_pkg::*;
#(
  parameter int MAX_BLOCK_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bit 0 of cfg_wdata is byte_swap.
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic        in_tlast,   // last_word
  input  logic        in_tuser,   // [0] forget_previous
  // Decoded samples.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] sample, [43:32] sample_index, [47:44] zero
  output logic        out_tlast   // last_of_word
);

  word_res_t         res;
  logic              in_accept;
  logic [WordW-1:0]  sample;
  logic [IndexW-1:0] sample_index;

  // An input word is consumed at every input transfer.
  assign in_accept = in_tvalid & in_tready;

  // The decoder keeps all block state and turns one word into its samples.
  steim1_decode #(
    .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .accept         (in_accept),
    .data_word      (in_tdata),
    .last_word      (in_tlast),
    .forget_previous(in_tuser),
    .res            (res)
  );

  // The buffer separates the two sides and serializes samples onto the output.
  steim1_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_accept),
    .res         (res),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .sample      (sample),
    .sample_index(sample_index),
    .last_of_word(out_tlast),
    .can_take    (in_tready)
  );

  // The output word is padded to whole bytes with zeros.
  assign out_tdata = {4'b0000, sample_index, sample};

endmodule

[sv/steim1_checker.sv]
// Port-level checker for the Steim-1 block decompressor, with its bind.
`include "steim1_block_decompressor_assert.svh"

module steim1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // A waiting sample stays offered.
  `STEIM1_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // Input is only open beside pending output when that output is the word's last.
  `STEIM1_ASSERT_NOW(a_ready_on_last, in_tready && out_tvalid, out_tlast && out_tready)

  // Samples of one word follow each other with consecutive indexes.
  `STEIM1_ASSERT_NEXT(a_index_step, out_tvalid && out_tready && !out_tlast,
                      out_tvalid && (out_tdata[43:32] == 12'($past(out_tdata[43:32]) + 1)))

  // Reset empties the result buffer.
  `STEIM1_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind steim1_block_decompressor steim1_checker u_steim1_checker (.*);
